// ===== rtl/orientation_matrix_from_up_forward_core_macros.svh =====
// ----------------------------------------------------------------------------
// Orientation basis core: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ORIENTATION_MATRIX_FROM_UP_FORWARD_CORE_MACROS_SVH
`define ORIENTATION_MATRIX_FROM_UP_FORWARD_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define OMF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked after the antecedent, delayed by the dly argument.
`define OMF_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ===== rtl/omf_pkg.sv =====
// ----------------------------------------------------------------------------
// Orientation basis package
// Item types, fixed widths and constants shared by the core and its units.
// ----------------------------------------------------------------------------
package omf_pkg;

  localparam int unsigned OUT_FRAC_BITS_DEF = 14;
  localparam int unsigned IN_W          = 32;
  localparam int unsigned OUT_W         = 16;
  localparam int unsigned VEC_W         = 64;
  localparam int unsigned NUM_BYTES     = VEC_W / 8;
  localparam int unsigned BLK_MSB       = 29;
  localparam int unsigned MAG_W         = 30;
  localparam int unsigned ROOT_W        = 31;
  localparam int unsigned SQ_W          = 62;
  localparam int unsigned SMALL_C_BITS  = 24;
  localparam logic [16:0] DEGEN_RECIP   = 17'd100000;
  localparam int unsigned UNIT_M_LAT    = 4;
  localparam int unsigned UNIT_PRE_LAT  = 6;

  typedef logic signed [VEC_W-1:0] omf_vec_t;
  typedef logic signed [MAG_W:0]   omf_blk_t;
  typedef logic signed [OUT_W-1:0] omf_word_t;

  typedef struct packed {
    logic signed [IN_W-1:0] up_x;
    logic signed [IN_W-1:0] up_y;
    logic signed [IN_W-1:0] up_z;
    logic signed [IN_W-1:0] fwd_x;
    logic signed [IN_W-1:0] fwd_y;
    logic signed [IN_W-1:0] fwd_z;
  } omf_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] side_x;
    logic signed [OUT_W-1:0] side_y;
    logic signed [OUT_W-1:0] side_z;
    logic signed [OUT_W-1:0] norm_up_x;
    logic signed [OUT_W-1:0] norm_up_y;
    logic signed [OUT_W-1:0] norm_up_z;
    logic signed [OUT_W-1:0] norm_fwd_x;
    logic signed [OUT_W-1:0] norm_fwd_y;
    logic signed [OUT_W-1:0] norm_fwd_z;
    logic                    degenerate;
  } omf_out_t;

  // Depth from a unit input to its unit row: front end, root, setup, quotient, sign.
  function automatic int unsigned omf_unit_lat(input int unsigned frac);
    return UNIT_PRE_LAT + ROOT_W + frac + 3;
  endfunction

endpackage

// ===== rtl/omf_unit.sv =====
// ----------------------------------------------------------------------------
// Orientation basis: vector normalisation unit
// Block scales a signed vector so its largest magnitude sits in [2^29, 2^30),
// takes the integer root of its squared length one bit a stage, then divides
// each component by it one quotient bit a stage, rounding to nearest.
// ----------------------------------------------------------------------------
module omf_unit
  import omf_pkg::*;
#(
  parameter int unsigned FracBits = OUT_FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  omf_vec_t  vec_i [3],
  output logic      vm_o,
  output omf_blk_t  m_o [3],
  output logic      vq_o,
  output omf_word_t q_o [3]
);

  localparam int unsigned QuotW = FracBits + 1;
  localparam int unsigned NumW  = FracBits + ROOT_W + 1;
  localparam int unsigned SgnW  = FracBits + 2;
  localparam int unsigned PosW  = $clog2(VEC_W);

  // Stage 1: magnitudes, signs, OR of magnitudes
  logic [VEC_W-1:0] mag_s1_d [3];
  logic [VEC_W-1:0] mag_s1_q [3];
  logic [2:0]       neg_s1_d, neg_s1_q;
  logic [VEC_W-1:0] or_s1_d, or_s1_q;
  logic             v_s1_q;

  always_comb begin
    or_s1_d = '0;
    for (int i = 0; i < 3; i++) begin
      neg_s1_d[i] = vec_i[i][VEC_W-1];
      mag_s1_d[i] = neg_s1_d[i] ? (VEC_W'(~vec_i[i]) + VEC_W'(1)) : VEC_W'(vec_i[i]);
      or_s1_d     = or_s1_d | mag_s1_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    mag_s1_q <= mag_s1_d;
    neg_s1_q <= neg_s1_d;
    or_s1_q  <= or_s1_d;
  end

  // Stage 2: per-byte leading one
  logic [NUM_BYTES-1:0] bnz_s2_d, bnz_s2_q;
  logic [2:0]           bidx_s2_d [NUM_BYTES];
  logic [2:0]           bidx_s2_q [NUM_BYTES];
  logic [VEC_W-1:0]     mag_s2_q [3];
  logic [2:0]           neg_s2_q;
  logic                 v_s2_q;

  always_comb begin
    for (int b = 0; b < NUM_BYTES; b++) begin
      bnz_s2_d[b]  = |or_s1_q[8*b +: 8];
      bidx_s2_d[b] = '0;
      for (int k = 0; k < 8; k++) begin
        if (or_s1_q[8*b + k]) begin
          bidx_s2_d[b] = 3'(k);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bnz_s2_q  <= bnz_s2_d;
    bidx_s2_q <= bidx_s2_d;
    mag_s2_q  <= mag_s1_q;
    neg_s2_q  <= neg_s1_q;
  end

  // Stage 3: leading one position and shift amounts
  logic [PosW-1:0]  top_pos;
  logic [PosW-1:0]  lsh_s3_d, lsh_s3_q, rsh_s3_d, rsh_s3_q;
  logic [VEC_W-1:0] mag_s3_q [3];
  logic [2:0]       neg_s3_q;
  logic             v_s3_q;

  always_comb begin
    top_pos = '0;
    for (int b = 0; b < NUM_BYTES; b++) begin
      if (bnz_s2_q[b]) begin
        top_pos = {3'(b), bidx_s2_q[b]};
      end
    end
    if (top_pos >= PosW'(BLK_MSB)) begin
      rsh_s3_d = top_pos - PosW'(BLK_MSB);
      lsh_s3_d = '0;
    end else begin
      rsh_s3_d = '0;
      lsh_s3_d = PosW'(BLK_MSB) - top_pos;
    end
  end

  always_ff @(posedge clk_i) begin
    lsh_s3_q <= lsh_s3_d;
    rsh_s3_q <= rsh_s3_d;
    mag_s3_q <= mag_s2_q;
    neg_s3_q <= neg_s2_q;
  end

  // Stage 4: block scaled magnitudes
  logic [VEC_W-1:0] sh_s4 [3];
  logic [MAG_W-1:0] mm_s4_d [3];
  logic [MAG_W-1:0] mm_s4_q [3];
  logic [2:0]       neg_s4_q;
  logic             v_s4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh_s4[i]   = (mag_s3_q[i] << lsh_s3_q) >> rsh_s3_q;
      mm_s4_d[i] = sh_s4[i][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    mm_s4_q  <= mm_s4_d;
    neg_s4_q <= neg_s3_q;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_o[i] = neg_s4_q[i] ? (~{1'b0, mm_s4_q[i]} + 1'b1) : {1'b0, mm_s4_q[i]};
    end
  end

  assign vm_o = v_s4_q;

  // Stage 5: squares
  logic [2*MAG_W-1:0] sq_s5_d [3];
  logic [2*MAG_W-1:0] sq_s5_q [3];
  logic [MAG_W-1:0]   mm_s5_q [3];
  logic [2:0]         neg_s5_q;
  logic               v_s5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_s5_d[i] = mm_s4_q[i] * mm_s4_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    sq_s5_q  <= sq_s5_d;
    mm_s5_q  <= mm_s4_q;
    neg_s5_q <= neg_s4_q;
  end

  // Stage 6 and root stages: index 0 holds the squared length
  logic [SQ_W-1:0]   rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];
  logic [MAG_W-1:0]  amag_q [ROOT_W+1][3];
  logic [2:0]        sneg_q [ROOT_W+1];
  logic              sv_q   [ROOT_W+1];

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= SQ_W'(sq_s5_q[0]) + SQ_W'(sq_s5_q[1]) + SQ_W'(sq_s5_q[2]);
    root_q[0] <= '0;
    amag_q[0] <= mm_s5_q;
    sneg_q[0] <= neg_s5_q;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam int unsigned Bit = ROOT_W - 1 - k;
    logic [VEC_W-1:0]  trial;
    logic [SQ_W-1:0]   rem_d;
    logic [ROOT_W-1:0] root_d;

    always_comb begin
      trial  = (VEC_W'(root_q[k]) << (Bit + 1)) + (VEC_W'(1) << (2 * Bit));
      rem_d  = rem_q[k];
      root_d = root_q[k];
      if (VEC_W'(rem_q[k]) >= trial) begin
        rem_d  = rem_q[k] - trial[SQ_W-1:0];
        root_d = root_q[k] | (ROOT_W'(1) << Bit);
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= rem_d;
      root_q[k+1] <= root_d;
      amag_q[k+1] <= amag_q[k];
      sneg_q[k+1] <= sneg_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else begin
        sv_q[k+1] <= sv_q[k];
      end
    end
  end

  // Divider setup: index 0 holds the rounded numerators
  logic [NumW-1:0]   drem_q [QuotW+1][3];
  logic [QuotW-1:0]  quot_q [QuotW+1][3];
  logic [ROOT_W-1:0] dr_q   [QuotW+1];
  logic              rz_q   [QuotW+1];
  logic [2:0]        dneg_q [QuotW+1];
  logic              dv_q   [QuotW+1];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      drem_q[0][i] <= (NumW'(amag_q[ROOT_W][i]) << FracBits) + NumW'(root_q[ROOT_W] >> 1);
      quot_q[0][i] <= '0;
    end
    dr_q[0]   <= root_q[ROOT_W];
    rz_q[0]   <= (root_q[ROOT_W] == '0);
    dneg_q[0] <= sneg_q[ROOT_W];
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_div
    localparam int unsigned Bit = QuotW - 1 - k;
    logic [NumW-1:0]  den;
    logic [NumW-1:0]  drem_d [3];
    logic [QuotW-1:0] quot_d [3];

    always_comb begin
      den = NumW'(dr_q[k]) << Bit;
      for (int i = 0; i < 3; i++) begin
        drem_d[i] = drem_q[k][i];
        quot_d[i] = quot_q[k][i];
        if (drem_q[k][i] >= den) begin
          drem_d[i] = drem_q[k][i] - den;
          quot_d[i] = quot_q[k][i] | (QuotW'(1) << Bit);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      drem_q[k+1] <= drem_d;
      quot_q[k+1] <= quot_d;
      dr_q[k+1]   <= dr_q[k];
      rz_q[k+1]   <= rz_q[k];
      dneg_q[k+1] <= dneg_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else begin
        dv_q[k+1] <= dv_q[k];
      end
    end
  end

  // Final stage: restore signs, wrap into the output word
  logic [QuotW-1:0]       qm [3];
  logic signed [SgnW-1:0] qs [3];
  omf_word_t              q_d [3];
  omf_word_t              q_q [3];
  logic                   vq_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qm[i]  = rz_q[QuotW] ? '0 : quot_q[QuotW][i];
      qs[i]  = dneg_q[QuotW][i] ? -$signed({1'b0, qm[i]}) : $signed({1'b0, qm[i]});
      q_d[i] = 16'(qs[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o  = q_q;
  assign vq_o = vq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s1_q   <= 1'b0;
      v_s2_q   <= 1'b0;
      v_s3_q   <= 1'b0;
      v_s4_q   <= 1'b0;
      v_s5_q   <= 1'b0;
      sv_q[0]  <= 1'b0;
      dv_q[0]  <= 1'b0;
      vq_q     <= 1'b0;
    end else begin
      v_s1_q   <= valid_i;
      v_s2_q   <= v_s1_q;
      v_s3_q   <= v_s2_q;
      v_s4_q   <= v_s3_q;
      v_s5_q   <= v_s4_q;
      sv_q[0]  <= v_s5_q;
      dv_q[0]  <= sv_q[ROOT_W];
      vq_q     <= dv_q[QuotW];
    end
  end

endmodule

// ===== rtl/orientation_matrix_from_up_forward_core.sv =====
// ----------------------------------------------------------------------------
// Orientation basis core
// Turns a raw signed up vector and forward vector into a 3x3 rotation basis
// in signed fixed point with OUT_FRAC_BITS fraction bits (Q1.14 by default).
// Input channel: drive in_i and raise start; the item is taken at the clock
// edge where start is high and busy is low. busy stays low: the pipeline takes
// a new item in every cycle.
// Result channel: valid_o is high for exactly one cycle with res_o holding
// side, normalised up and perpendicular forward rows plus the degenerate flag.
// Results leave in input order. The receiver cannot hold them off.
// Depth: an item passes the front end of the up and side units, the cross
// stages and the whole forward unit with its 31-stage root and
// one-bit-per-stage divider, then the output register.
// Throughput: one item per cycle.
// Reset: rst_ni clears every valid bit; items in flight are dropped.
// ----------------------------------------------------------------------------
`include "orientation_matrix_from_up_forward_core_macros.svh"

module orientation_matrix_from_up_forward_core
  import omf_pkg::*;
#(
  parameter int unsigned OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  omf_in_t  in_i,
  output logic     valid_o,
  output omf_out_t res_o
);

  localparam int unsigned UnitLat  = omf_unit_lat(OUT_FRAC_BITS);
  localparam int unsigned DegDly   = UnitLat + 2;
  localparam int unsigned RowDly   = UNIT_M_LAT + 2;
  localparam int unsigned TotalLat = UnitLat + 9;
  localparam logic [31:0] OneWide  = 32'd1 << OUT_FRAC_BITS;
  localparam omf_word_t   One      = OneWide[OUT_W-1:0];

  assign busy = 1'b0;

  // Stage 1: cross and square products
  logic signed [VEC_W-1:0] pr_s1_d [6];
  logic signed [VEC_W-1:0] pr_s1_q [6];
  logic signed [VEC_W-1:0] us_s1_d [3];
  logic signed [VEC_W-1:0] us_s1_q [3];
  logic signed [IN_W-1:0]  u_s1_q  [3];
  logic                    v_s1_q;

  always_comb begin
    pr_s1_d[0] = in_i.up_y * in_i.fwd_z;
    pr_s1_d[1] = in_i.up_z * in_i.fwd_y;
    pr_s1_d[2] = in_i.up_z * in_i.fwd_x;
    pr_s1_d[3] = in_i.up_x * in_i.fwd_z;
    pr_s1_d[4] = in_i.up_x * in_i.fwd_y;
    pr_s1_d[5] = in_i.up_y * in_i.fwd_x;
    us_s1_d[0] = in_i.up_x * in_i.up_x;
    us_s1_d[1] = in_i.up_y * in_i.up_y;
    us_s1_d[2] = in_i.up_z * in_i.up_z;
  end

  always_ff @(posedge clk_i) begin
    pr_s1_q   <= pr_s1_d;
    us_s1_q   <= us_s1_d;
    u_s1_q[0] <= in_i.up_x;
    u_s1_q[1] <= in_i.up_y;
    u_s1_q[2] <= in_i.up_z;
  end

  // Stage 2: c = up x fwd and |up|^2
  omf_vec_t               c_s2_q [3];
  logic [VEC_W-1:0]       usq_s2_q;
  logic signed [IN_W-1:0] u_s2_q [3];
  omf_vec_t               ua_vec [3];
  logic                   v_s2_q;

  always_ff @(posedge clk_i) begin
    c_s2_q[0] <= pr_s1_q[0] - pr_s1_q[1];
    c_s2_q[1] <= pr_s1_q[2] - pr_s1_q[3];
    c_s2_q[2] <= pr_s1_q[4] - pr_s1_q[5];
    usq_s2_q  <= VEC_W'(us_s1_q[0]) + VEC_W'(us_s1_q[1]) + VEC_W'(us_s1_q[2]);
    u_s2_q    <= u_s1_q;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ua_vec[i] = VEC_W'(u_s2_q[i]);
    end
  end

  // Stage 3: small-cross test and squares of c
  logic                                small_s3_d, small_s3_q;
  logic signed [SMALL_C_BITS:0]        cl_s3 [3];
  logic signed [2*SMALL_C_BITS+1:0]    csq_s3_d [3];
  logic signed [2*SMALL_C_BITS+1:0]    csq_s3_q [3];
  logic [VEC_W-1:0]                    usq_s3_q;

  always_comb begin
    small_s3_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (!((c_s2_q[i][VEC_W-1:SMALL_C_BITS] == '0) ||
            ((&c_s2_q[i][VEC_W-1:SMALL_C_BITS]) && (|c_s2_q[i][SMALL_C_BITS-1:0])))) begin
        small_s3_d = 1'b0;
      end
      cl_s3[i]    = c_s2_q[i][SMALL_C_BITS:0];
      csq_s3_d[i] = cl_s3[i] * cl_s3[i];
    end
  end

  always_ff @(posedge clk_i) begin
    small_s3_q <= small_s3_d;
    csq_s3_q   <= csq_s3_d;
    usq_s3_q   <= usq_s2_q;
  end

  // Stage 4: |c|^2
  logic [2*SMALL_C_BITS+1:0] csum_s4_q;
  logic                      small_s4_q;
  logic [VEC_W-1:0]          usq_s4_q;

  always_ff @(posedge clk_i) begin
    csum_s4_q  <= csq_s3_q[0] + csq_s3_q[1] + csq_s3_q[2];
    small_s4_q <= small_s3_q;
    usq_s4_q   <= usq_s3_q;
  end

  // Stage 5: scale |c|^2 by the threshold reciprocal
  localparam int unsigned ProdW = 2*SMALL_C_BITS + 2 + 17;
  logic [ProdW-1:0] prod_s5_q;
  logic             small_s5_q;
  logic [VEC_W-1:0] usq_s5_q;

  always_ff @(posedge clk_i) begin
    prod_s5_q  <= ProdW'(csum_s4_q) * ProdW'(DEGEN_RECIP);
    small_s5_q <= small_s4_q;
    usq_s5_q   <= usq_s4_q;
  end

  // Stage 6: degenerate decision, then hold it until the rows arrive
  logic degen_s6_q;
  logic dg_q [DegDly];

  always_ff @(posedge clk_i) begin
    degen_s6_q <= small_s5_q && (prod_s5_q <= ProdW'(usq_s5_q));
    dg_q[0]    <= degen_s6_q;
    for (int k = 1; k < DegDly; k++) begin
      dg_q[k] <= dg_q[k-1];
    end
  end

  // Units for up and for c
  logic      va_m, vb_m, va_q, vb_q;
  omf_blk_t  bu [3];
  omf_blk_t  bc [3];
  omf_word_t up_row [3];
  omf_word_t side_row [3];

  omf_unit #(
    .FracBits(OUT_FRAC_BITS)
  ) u_unit_up (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v_s2_q),
    .vec_i  (ua_vec),
    .vm_o   (va_m),
    .m_o    (bu),
    .vq_o   (va_q),
    .q_o    (up_row)
  );

  omf_unit #(
    .FracBits(OUT_FRAC_BITS)
  ) u_unit_side (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v_s2_q),
    .vec_i  (c_s2_q),
    .vm_o   (vb_m),
    .m_o    (bc),
    .vq_o   (vb_q),
    .q_o    (side_row)
  );

  // Cross stages: w = bc x bu
  logic signed [2*MAG_W+1:0] wp_x1_q [6];
  logic                      v_x1_q;
  omf_vec_t                  w_x2_q [3];
  logic                      v_x2_q;

  always_ff @(posedge clk_i) begin
    wp_x1_q[0] <= bc[1] * bu[2];
    wp_x1_q[1] <= bc[2] * bu[1];
    wp_x1_q[2] <= bc[2] * bu[0];
    wp_x1_q[3] <= bc[0] * bu[2];
    wp_x1_q[4] <= bc[0] * bu[1];
    wp_x1_q[5] <= bc[1] * bu[0];
    w_x2_q[0]  <= VEC_W'(wp_x1_q[0]) - VEC_W'(wp_x1_q[1]);
    w_x2_q[1]  <= VEC_W'(wp_x1_q[2]) - VEC_W'(wp_x1_q[3]);
    w_x2_q[2]  <= VEC_W'(wp_x1_q[4]) - VEC_W'(wp_x1_q[5]);
  end

  logic      vc_m, vc_q;
  omf_blk_t  bw [3];
  omf_word_t fwd_row [3];

  omf_unit #(
    .FracBits(OUT_FRAC_BITS)
  ) u_unit_fwd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v_x2_q),
    .vec_i  (w_x2_q),
    .vm_o   (vc_m),
    .m_o    (bw),
    .vq_o   (vc_q),
    .q_o    (fwd_row)
  );

  // Hold the up and side rows until the forward row is ready
  omf_word_t up_dly_q   [RowDly][3];
  omf_word_t side_dly_q [RowDly][3];

  always_ff @(posedge clk_i) begin
    up_dly_q[0]   <= up_row;
    side_dly_q[0] <= side_row;
    for (int k = 1; k < RowDly; k++) begin
      up_dly_q[k]   <= up_dly_q[k-1];
      side_dly_q[k] <= side_dly_q[k-1];
    end
  end

  // Output register
  omf_out_t res_d, res_q;
  logic     valid_q;

  always_comb begin
    if (dg_q[DegDly-1]) begin
      res_d.side_x     = One;
      res_d.side_y     = '0;
      res_d.side_z     = '0;
      res_d.norm_up_x  = '0;
      res_d.norm_up_y  = One;
      res_d.norm_up_z  = '0;
      res_d.norm_fwd_x = '0;
      res_d.norm_fwd_y = '0;
      res_d.norm_fwd_z = One;
      res_d.degenerate = 1'b1;
    end else begin
      res_d.side_x     = side_dly_q[RowDly-1][0];
      res_d.side_y     = side_dly_q[RowDly-1][1];
      res_d.side_z     = side_dly_q[RowDly-1][2];
      res_d.norm_up_x  = up_dly_q[RowDly-1][0];
      res_d.norm_up_y  = up_dly_q[RowDly-1][1];
      res_d.norm_up_z  = up_dly_q[RowDly-1][2];
      res_d.norm_fwd_x = fwd_row[0];
      res_d.norm_fwd_y = fwd_row[1];
      res_d.norm_fwd_z = fwd_row[2];
      res_d.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s1_q  <= 1'b0;
      v_s2_q  <= 1'b0;
      v_x1_q  <= 1'b0;
      v_x2_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      v_s1_q  <= start && !busy;
      v_s2_q  <= v_s1_q;
      v_x1_q  <= va_m && vb_m;
      v_x2_q  <= v_x1_q;
      valid_q <= vc_q;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  // Assertions
  `OMF_ASSERT_DLY(a_item_latency, start && !busy, TotalLat, valid_o, "item result missing at fixed latency")
  `OMF_ASSERT_IMP(a_result_source, valid_o, $past(start && !busy, TotalLat), "result without an accepted item")
  `OMF_ASSERT_IMP(a_unit_align, va_m || vb_m || va_q || vb_q, (va_m == vb_m) && (va_q == vb_q), "up and side units out of step")
  `OMF_ASSERT_IMP(a_fwd_align, vc_m, $past(va_m, 2 + UNIT_M_LAT), "forward unit out of step")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Orientation basis core testbench
// Sends raw up/forward vector pairs, predicts each cross-product basis
// exactly in integers and checks every result field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import omf_pkg::*;

  localparam int unsigned FRAC      = 14;
  localparam int          WDOG_MAX  = 3000;
  localparam int          TAIL_CYC  = 49 + FRAC + 10;
  localparam int          N_RANDOM  = 1330;

  typedef logic signed [63:0] wide_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  omf_in_t  in_i;
  logic     valid_o;
  omf_out_t res_o;

  omf_out_t basis_q[$];
  int       n_errors;
  int       n_sent;
  int       n_results;
  int       n_degen;
  int       idle_cycles;
  bit       took_item;

  orientation_matrix_from_up_forward_core #(.OUT_FRAC_BITS(FRAC)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Basis predictor
  // --------------------------------------------------------------------------
  function automatic logic [63:0] magnitude(wide_t v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void cross_prod(input wide_t a[3], input wide_t b[3], output wide_t o[3]);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // Shift so the largest magnitude lands in [2^29, 2^30); right shifts truncate.
  function automatic void block_norm(input wide_t v[3], output wide_t m[3]);
    logic [63:0] a[3];
    logic [63:0] top, s;
    int left, right;
    top = 0;
    left = 0;
    right = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = magnitude(v[i]);
      if (a[i] > top) top = a[i];
    end
    if (top == 0) begin
      for (int i = 0; i < 3; i++) m[i] = 0;
      return;
    end
    while (top < (64'd1 << 29)) begin
      top = top << 1;
      left++;
    end
    while (top >= (64'd1 << 30)) begin
      top = top >> 1;
      right++;
    end
    for (int i = 0; i < 3; i++) begin
      s = (a[i] << left) >> right;
      m[i] = v[i] < 0 ? -wide_t'(s) : wide_t'(s);
    end
  endfunction

  function automatic void unit_row(input wide_t m[3], output omf_word_t q[3]);
    logic [63:0] a[3];
    logic [63:0] sum, r, qm;
    wide_t sq;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = magnitude(m[i]);
      sum += a[i] * a[i];
    end
    r = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      qm = (r != 0) ? ((a[i] << FRAC) + (r >> 1)) / r : 64'd0;
      sq = m[i] < 0 ? -wide_t'(qm) : wide_t'(qm);
      q[i] = sq[15:0];
    end
  endfunction

  function automatic omf_out_t predict_basis(omf_in_t it);
    wide_t u[3], f[3], c[3], bu[3], bc[3], w[3], bw[3];
    omf_word_t rs[3], ru[3], rf[3];
    logic [63:0] usq, csq;
    logic tiny, degen;
    omf_out_t r;
    u[0] = it.up_x;  u[1] = it.up_y;  u[2] = it.up_z;
    f[0] = it.fwd_x; f[1] = it.fwd_y; f[2] = it.fwd_z;
    cross_prod(u, f, c);
    usq = 0;
    csq = 0;
    tiny = 1'b1;
    for (int i = 0; i < 3; i++) begin
      usq += magnitude(u[i]) * magnitude(u[i]);
      if (magnitude(c[i]) >= (64'd1 << 24)) tiny = 1'b0;
    end
    if (tiny) begin
      for (int i = 0; i < 3; i++) csq += magnitude(c[i]) * magnitude(c[i]);
      degen = (csq <= usq / 64'd100000);
    end else begin
      degen = 1'b0;
    end
    r = '0;
    if (degen) begin
      r.side_x     = omf_word_t'(1 << FRAC);
      r.norm_up_y  = omf_word_t'(1 << FRAC);
      r.norm_fwd_z = omf_word_t'(1 << FRAC);
      r.degenerate = 1'b1;
    end else begin
      block_norm(u, bu);
      unit_row(bu, ru);
      block_norm(c, bc);
      unit_row(bc, rs);
      cross_prod(bc, bu, w);
      block_norm(w, bw);
      unit_row(bw, rf);
      r.side_x = rs[0];     r.side_y = rs[1];     r.side_z = rs[2];
      r.norm_up_x = ru[0];  r.norm_up_y = ru[1];  r.norm_up_z = ru[2];
      r.norm_fwd_x = rf[0]; r.norm_fwd_y = rf[1]; r.norm_fwd_z = rf[2];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  function automatic omf_in_t make_item(int ux, int uy, int uz, int fx, int fy, int fz);
    omf_in_t it;
    it.up_x = ux;  it.up_y = uy;  it.up_z = uz;
    it.fwd_x = fx; it.fwd_y = fy; it.fwd_z = fz;
    return it;
  endfunction

  // Called at a rising edge; returns at the edge that took the item.
  task automatic send_vectors(omf_in_t it);
    bit held;
    start <= 1'b1;
    in_i  <= it;
    do begin
      @(negedge clk_i);
      held = busy;
      @(posedge clk_i);
    end while (held);
    basis_q.push_back(predict_basis(it));
    took_item = 1'b1;
    n_sent++;
  endtask

  task automatic idle_for(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (basis_q.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic check_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, got_v);
      n_errors++;
    end
  endtask

  initial begin
    omf_out_t e;
    forever begin
      @(negedge clk_i);
      if (rst_ni && valid_o) begin
        n_results++;
        if (basis_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $realtime, res_o);
          n_errors++;
        end else begin
          e = basis_q.pop_front();
          if (e.degenerate) n_degen++;
          check_field("side_x", e.side_x, res_o.side_x);
          check_field("side_y", e.side_y, res_o.side_y);
          check_field("side_z", e.side_z, res_o.side_z);
          check_field("norm_up_x", e.norm_up_x, res_o.norm_up_x);
          check_field("norm_up_y", e.norm_up_y, res_o.norm_up_y);
          check_field("norm_up_z", e.norm_up_z, res_o.norm_up_z);
          check_field("norm_fwd_x", e.norm_fwd_x, res_o.norm_fwd_x);
          check_field("norm_fwd_y", e.norm_fwd_y, res_o.norm_fwd_y);
          check_field("norm_fwd_z", e.norm_fwd_z, res_o.norm_fwd_z);
          check_field("degenerate", e.degenerate, res_o.degenerate);
        end
      end
    end
  end

  // Watchdog: count cycles in which no item is taken and no result appears.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      #1;
      if (took_item || valid_o) idle_cycles = 0;
      else idle_cycles++;
      took_item = 1'b0;
      if (idle_cycles >= WDOG_MAX) begin
        $display("Timeout: no progress for %0d cycles", WDOG_MAX);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    int mn, mx;
    mn = 32'sh8000_0000;
    mx = 32'sh7fff_ffff;
    send_vectors(make_item(0, 1, 0, 0, 0, 1));
    send_vectors(make_item(0, 0, 0, 5, 7, 9));            // zero up
    send_vectors(make_item(0, 0, 0, 0, 0, 0));
    send_vectors(make_item(3, -4, 5, 0, 0, 0));           // zero forward
    send_vectors(make_item(3, -4, 5, 6, -8, 10));         // parallel
    send_vectors(make_item(3, -4, 5, -9, 12, -15));       // anti-parallel
    send_vectors(make_item(mn, mn, mn, mn, mn, mn));
    send_vectors(make_item(mx, mx, mx, mx, mx, mx));
    send_vectors(make_item(mn, mn, mn, mx, mx, mx));
    send_vectors(make_item(mn, mx, mn, mx, mn, mx));
    send_vectors(make_item(mx, mn, 0, mn, mx, mn));
    send_vectors(make_item(-1, -1, -1, 1, -1, 1));
    send_vectors(make_item(1, 0, 0, 0, 1, 0));
    // Pairs for the degenerate test: near-parallel, parallel and perpendicular
    send_vectors(make_item(1000, 0, 0, 1000, 3, 0));
    send_vectors(make_item(1000, 0, 0, 1000, 4, 0));
    send_vectors(make_item(100000, 0, 0, 5, 0, 0));
    send_vectors(make_item(316, 0, 0, 0, 1, 0));
    send_vectors(make_item(317, 0, 0, 0, 1, 0));
    send_vectors(make_item(mx, 0, 0, 1, 0, 0));
    send_vectors(make_item(mx, 0, 0, 0, 0, 1));
    send_vectors(make_item(0, mn, 0, 0, 0, mn));
    send_vectors(make_item(12345, -678, 91011, -1213, 1415, -1617));
  endtask

  function automatic int small_val();
    return int'($urandom_range(0, 2000)) - 1000;
  endfunction

  function automatic omf_in_t random_item();
    omf_in_t it;
    int k;
    it = omf_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(0, 7))
      0, 1, 2: ;
      3: it = make_item(small_val(), small_val(), small_val(),
                        small_val(), small_val(), small_val());
      4: begin
        // forward close to a multiple of up
        k = int'($urandom_range(0, 6)) - 3;
        it.up_x = small_val() * 1000;
        it.up_y = small_val() * 1000;
        it.up_z = small_val() * 1000;
        it.fwd_x = it.up_x * k + int'($urandom_range(0, 2)) - 1;
        it.fwd_y = it.up_y * k + int'($urandom_range(0, 2)) - 1;
        it.fwd_z = it.up_z * k + int'($urandom_range(0, 2)) - 1;
      end
      5: begin
        it.up_x = 0;
        it.fwd_y = 0;
      end
      6: begin
        it.up_x = it.up_x >>> $urandom_range(0, 31);
        it.up_y = it.up_y >>> $urandom_range(0, 31);
        it.up_z = it.up_z >>> $urandom_range(0, 31);
        it.fwd_x = it.fwd_x >>> $urandom_range(0, 31);
        it.fwd_y = it.fwd_y >>> $urandom_range(0, 31);
        it.fwd_z = it.fwd_z >>> $urandom_range(0, 31);
      end
      default: it = make_item(0, 0, 0, small_val(), small_val(), small_val());
    endcase
    return it;
  endfunction

  task automatic test_random(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && n > 0) begin
        send_vectors(random_item());
        burst--;
        n--;
      end
      // Some bursts run straight into the next one
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 80));
    end
  endtask

  task automatic test_pause_and_refill();
    wait_drained();
    for (int i = 0; i < 8; i++) send_vectors(random_item());
  endtask

  initial begin
    n_errors = 0;
    n_sent = 0;
    n_results = 0;
    n_degen = 0;
    took_item = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pause_and_refill();
    test_random(N_RANDOM);
    wait_drained();
    // start is already low here; just let the pipeline settle
    repeat (TAIL_CYC) @(posedge clk_i);
    $display("Sent %0d items, checked %0d bases (%0d degenerate)",
             n_sent, n_results, n_degen);
    if (n_errors == 0 && basis_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, basis_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== orientation_matrix_from_up_forward_core.f =====
+incdir+rtl
rtl/omf_pkg.sv
rtl/omf_unit.sv
rtl/orientation_matrix_from_up_forward_core.sv
tb/sv/tb_top.sv
